/* rtl/waypoint_mission_sequencer_assert.svh */
// ---------------------------------------------------------------------------
// Waypoint mission sequencer assertion macros
// Shared forms for the concurrent checks of the sequencer, clocked on clk
// and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef WAYPOINT_MISSION_SEQUENCER_ASSERT_SVH
`define WAYPOINT_MISSION_SEQUENCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WMS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/wms_pkg.sv */
// ---------------------------------------------------------------------------
// Waypoint mission sequencer package
// Table sizes, command and status codes, sequencer states and the packed
// words of the command and result channels.
// ---------------------------------------------------------------------------
package wms_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int POS_W       = 32;
  localparam int THR_W       = 31;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 31'd6554;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_ADD    = 3'd1,
    OP_START  = 3'd2,
    OP_END    = 3'd3,
    OP_NEXT   = 3'd4,
    OP_TOGGLE = 3'd5,
    OP_OTHER  = 3'd6
  } op_t;

  typedef enum logic [3:0] {
    STS_NONE        = 4'd0,
    STS_ADDED       = 4'd1,
    STS_NO_POSITION = 4'd2,
    STS_FULL        = 4'd3,
    STS_STARTED     = 4'd4,
    STS_ENDED       = 4'd5,
    STS_ADVANCED    = 4'd6,
    STS_NOT_STARTED = 4'd7,
    STS_AT_LAST     = 4'd8,
    STS_AUTO_ON     = 4'd9,
    STS_AUTO_OFF    = 4'd10,
    STS_UNEXPECTED  = 4'd11
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIST,
    S_DONE
  } state_t;

  localparam logic [ADDR_W-1:0] REG_THRESHOLD = 3'd0;

  typedef struct packed {
    logic [2:0]              op;
    logic                    pos_valid;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } cmd_word_t;

  typedef struct packed {
    logic                    setpoint_valid;
    logic signed [POS_W-1:0] set_x;
    logic signed [POS_W-1:0] set_y;
    logic signed [POS_W-1:0] set_z;
    logic [IDX_W-1:0]        wp_index;
    logic [CNT_W-1:0]        mission_size;
    logic                    active;
    logic                    auto_on;
    logic [3:0]              status;
  } res_word_t;

endpackage

/* rtl/waypoint_mission_sequencer.sv */
// ---------------------------------------------------------------------------
// Waypoint mission sequencer
// Keeps a table of waypoints, runs a mission over them and sends the current
// waypoint as setpoint, advancing automatically on arrival when asked to.
// ---------------------------------------------------------------------------
// One command word is taken at a time. A word that needs no arrival check
// passes through acceptance, a table read and the result (accept, table read,
// result); one with an arrival check also passes through the distance step,
// where a single shared 32 by 32 squaring unit works through the three axis
// differences and the threshold. A result waits in its register until taken,
// and the next word is accepted only once the previous result has been placed
// there. The arrival threshold is register 0 at byte address 0 of the APB port.
`include "waypoint_mission_sequencer_assert.svh"

module waypoint_mission_sequencer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  wms_pkg::cmd_word_t         cmd,
  output logic                       res_valid,
  input  logic                       res_ready,
  output wms_pkg::res_word_t         res,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wms_pkg::ADDR_W-1:0] paddr,
  input  logic [wms_pkg::DATA_W-1:0] pwdata,
  output logic [wms_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  import wms_pkg::*;

  state_t state, state_next;
  logic [CNT_W-1:0] stored_count, stored_count_next;
  logic [CNT_W-1:0] mission_count, mission_count_next;
  logic [IDX_W-1:0] current_index, current_index_next;
  logic mission_flag, mission_flag_next;
  logic auto_flag, auto_flag_next;
  status_t status, status_next;
  logic [THR_W-1:0] threshold;
  logic [2:0] step;

  logic pos_valid;
  logic [POS_W-1:0] pos_x, pos_y, pos_z;
  logic [3*POS_W-1:0] mem [TABLE_DEPTH];
  logic [3*POS_W-1:0] rdata;
  logic wr_en;

  logic [POS_W-1:0] wp_sel, pos_sel;
  logic signed [POS_W:0] diff;
  logic [POS_W-1:0] mag_sel, mag;
  logic [2*POS_W-1:0] prod, acc;
  logic setpoint;
  logic [CNT_W-1:0] index_inc;
  logic has_next;
  logic done_fire;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_THRESHOLD[2]) ? {1'b0, threshold} : '0;
  assign cmd_ready = (state == S_IDLE);
  assign setpoint = mission_flag && (mission_count != '0);
  assign index_inc = CNT_W'(current_index) + CNT_W'(1);
  assign has_next  = (index_inc < mission_count);
  assign done_fire = (state == S_DONE) && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_THRESHOLD[2])) begin
      threshold <= pwdata[THR_W-1:0];
    end
  end

  always_comb begin
    case (step)
      3'd0: begin
        wp_sel  = rdata[POS_W-1:0];
        pos_sel = pos_x;
      end
      3'd1: begin
        wp_sel  = rdata[2*POS_W-1:POS_W];
        pos_sel = pos_y;
      end
      default: begin
        wp_sel  = rdata[3*POS_W-1:2*POS_W];
        pos_sel = pos_z;
      end
    endcase
    diff = $signed({wp_sel[POS_W-1], wp_sel}) - $signed({pos_sel[POS_W-1], pos_sel});
    if (step > 3'd2) begin
      mag_sel = {1'b0, threshold};
    end else if (!diff[POS_W] && diff[POS_W-1]) begin
      mag_sel = {1'b0, {(POS_W-1){1'b1}}};
    end else if (diff[POS_W] && !diff[POS_W-1]) begin
      mag_sel = {1'b1, {(POS_W-1){1'b0}}};
    end else if (diff[POS_W]) begin
      mag_sel = -diff[POS_W-1:0];
    end else begin
      mag_sel = diff[POS_W-1:0];
    end
  end

  always_comb begin
    state_next         = state;
    stored_count_next  = stored_count;
    mission_count_next = mission_count;
    current_index_next = current_index;
    mission_flag_next  = mission_flag;
    auto_flag_next     = auto_flag;
    status_next        = status;
    wr_en              = 1'b0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_READ;
          case (op_t'(cmd.op))
            OP_TICK: begin
              status_next = STS_NONE;
            end
            OP_ADD: begin
              if (!cmd.pos_valid) begin
                status_next = STS_NO_POSITION;
              end else if (stored_count == CNT_W'(TABLE_DEPTH)) begin
                status_next = STS_FULL;
              end else begin
                wr_en             = 1'b1;
                stored_count_next = stored_count + CNT_W'(1);
                status_next       = STS_ADDED;
              end
            end
            OP_START: begin
              mission_flag_next  = 1'b1;
              current_index_next = '0;
              mission_count_next = stored_count;
              status_next        = STS_STARTED;
            end
            OP_END: begin
              mission_flag_next = 1'b0;
              status_next       = STS_ENDED;
            end
            OP_NEXT: begin
              if (!mission_flag) begin
                status_next = STS_NOT_STARTED;
              end else if (has_next) begin
                current_index_next = index_inc[IDX_W-1:0];
                status_next        = STS_ADVANCED;
              end else begin
                status_next = STS_AT_LAST;
              end
            end
            OP_TOGGLE: begin
              auto_flag_next = !auto_flag;
              status_next    = auto_flag ? STS_AUTO_OFF : STS_AUTO_ON;
            end
            default: begin
              status_next = STS_UNEXPECTED;
            end
          endcase
        end
      end
      S_READ: begin
        state_next = (setpoint && auto_flag && pos_valid) ? S_DIST : S_DONE;
      end
      S_DIST: begin
        if (step == 3'd5) begin
          state_next = S_DONE;
          if (acc < prod) begin
            current_index_next = has_next ? index_inc[IDX_W-1:0] : '0;
          end
        end
      end
      S_DONE: begin
        if (!res_valid || res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      stored_count  <= '0;
      mission_count <= '0;
      current_index <= '0;
      mission_flag  <= 1'b0;
      auto_flag     <= 1'b0;
      status        <= STS_NONE;
      res_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      stored_count  <= stored_count_next;
      mission_count <= mission_count_next;
      current_index <= current_index_next;
      mission_flag  <= mission_flag_next;
      auto_flag     <= auto_flag_next;
      status        <= status_next;
      res_valid     <= done_fire || (res_valid && !res_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[stored_count[IDX_W-1:0]] <= {cmd.pos_z, cmd.pos_y, cmd.pos_x};
    end
    if (state == S_READ) begin
      rdata <= mem[current_index];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      pos_valid <= cmd.pos_valid;
      pos_x     <= cmd.pos_x;
      pos_y     <= cmd.pos_y;
      pos_z     <= cmd.pos_z;
    end
    if (state == S_DIST) begin
      step <= step + 3'd1;
    end else begin
      step <= '0;
    end
    mag  <= mag_sel;
    prod <= mag * mag;
    if (step == 3'd2) begin
      acc <= prod;
    end else if (step == 3'd3 || step == 3'd4) begin
      acc <= acc + prod;
    end
    if (done_fire) begin
      res.setpoint_valid <= setpoint;
      res.set_x          <= setpoint ? rdata[POS_W-1:0] : '0;
      res.set_y          <= setpoint ? rdata[2*POS_W-1:POS_W] : '0;
      res.set_z          <= setpoint ? rdata[3*POS_W-1:2*POS_W] : '0;
      res.wp_index       <= current_index;
      res.mission_size   <= mission_count;
      res.active         <= mission_flag;
      res.auto_on        <= auto_flag;
      res.status         <= status;
    end
  end

  `WMS_ASSERT_SAME(a_count_bound, 1'b1, stored_count <= CNT_W'(TABLE_DEPTH), "table overfilled")
  `WMS_ASSERT_SAME(a_mission_le_stored, 1'b1, mission_count <= stored_count, "mission too long")
  `WMS_ASSERT_SAME(a_index_in_mission, res_valid && res.setpoint_valid, CNT_W'(res.wp_index) < res.mission_size, "index beyond mission")
  `WMS_ASSERT_SAME(a_unused_setpoint_zero, res_valid && !res.setpoint_valid, res.set_x == '0 && res.set_y == '0 && res.set_z == '0, "unused setpoint not cleared")
  `WMS_ASSERT_NEXT(a_accept_reads, cmd_valid && cmd_ready, state == S_READ && !cmd_ready, "accepted word not read")

endmodule
